>>> hdl/cfr_pkg.sv
// shared types and a constant for the continued-fraction rationalizer
`default_nettype none
package cfr_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } cfr_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic update;
        logic emit;
    } cfr_cmd_t;

    typedef struct packed {
        logic pass;
        logic div_done;
    } cfr_status_t;

    localparam logic [31:0] TOL_RESET = 32'd4295;

endpackage
`default_nettype wire

>>> hdl/cfr_ctrl.sv
// sequencer for the continued-fraction expansion
`default_nettype none
module cfr_ctrl
    import cfr_pkg::*;
#(
    parameter int MAX_TERMS = 48
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  cfr_status_t      status,
    output cfr_cmd_t         cmd,
    output logic [6:0]       terms
);
    cfr_state_t state_reg, state_next;
    logic [6:0] terms_reg, terms_next;
    logic       mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            terms_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            terms_reg  <= terms_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        terms_next  = terms_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        cfg_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = (!mvalid_reg || m_tready) && !cfg_valid;
                if (mvalid_reg && m_tready) mvalid_next = 1'b0;
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    terms_next = 7'd1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (mvalid_reg && m_tready) mvalid_next = 1'b0;
                if (status.pass || terms_reg >= 7'(MAX_TERMS)) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mvalid_reg && m_tready) mvalid_next = 1'b0;
                if (status.div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (mvalid_reg && m_tready) mvalid_next = 1'b0;
                cmd.update = 1'b1;
                terms_next = terms_reg + 7'd1;
                state_next = ST_TEST;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.emit    = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign terms    = terms_reg;

`ifndef SYNTHESIS
    a_terms_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        terms_reg <= 7'(MAX_TERMS))
        else $error("term count overflow");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!mvalid_reg || m_tready)) |=> mvalid_reg)
        else $error("result lost");
`endif

endmodule
`default_nettype wire

>>> hdl/cfr_div.sv
// radix-2 restoring divider for the euclid quotient
`default_nettype none
module cfr_div #(
    parameter int W = 33
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic              step,
    output logic              qbit,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;
    logic [W:0]    sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        sh        = {r_reg[W-1:0], q_reg[W-1]};
        trial     = sh - {1'b0, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end else begin
            done = 1'b0;
        end
        if (busy_reg && cnt_reg == CW'(1)) done = 1'b1;
    end

    // quotient bits leave msb first, one per busy cycle
    assign step      = busy_reg && !start;
    assign qbit      = !trial[W];
    assign remainder = r_next[W-1:0];

endmodule
`default_nettype wire

>>> hdl/cfr_dp.sv
// euclid and convergent datapath
`default_nettype none
module cfr_dp
    import cfr_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [63:0] value,
    input  wire logic [31:0] tolerance,
    input  cfr_cmd_t         cmd,
    output cfr_status_t      status,
    output logic [63:0]      numerator,
    output logic [32:0]      denominator
);
    localparam int W = FRAC_BITS + 1;

    logic [W-1:0] num_reg, rem_reg, nrem_reg;
    logic [63:0]  p_reg, pp_reg, pacc_reg;
    logic [W-1:0] q_reg, qp_reg, qacc_reg;
    logic [63:0]  tq_reg, tqp_reg, tacc_reg;
    logic [W-1:0] rmd;
    logic         dv_done;
    logic         dv_step;
    logic         dv_bit;
    logic [63:0]  a0;

    cfr_div #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (num_reg),
        .divisor   (rem_reg),
        .done      (dv_done),
        .step      (dv_step),
        .qbit      (dv_bit),
        .remainder (rmd)
    );

    assign a0 = 64'($signed(value) >>> FRAC_BITS);

    // a*p, a*q and a*tol*q built by shift and add as quotient bits arrive
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            num_reg <= W'(1) << FRAC_BITS;
            rem_reg <= W'(value[FRAC_BITS-1:0]);
            p_reg   <= a0;
            pp_reg  <= 64'd1;
            q_reg   <= W'(1);
            qp_reg  <= '0;
            tq_reg  <= 64'(tolerance);
            tqp_reg <= '0;
        end
        if (cmd.div_start) begin
            pacc_reg <= '0;
            qacc_reg <= '0;
            tacc_reg <= '0;
        end else if (dv_step) begin
            pacc_reg <= {pacc_reg[62:0], 1'b0} + (dv_bit ? p_reg : 64'd0);
            qacc_reg <= {qacc_reg[W-2:0], 1'b0} + (dv_bit ? q_reg : {W{1'b0}});
            tacc_reg <= {tacc_reg[62:0], 1'b0} + (dv_bit ? tq_reg : 64'd0);
        end
        if (dv_done) nrem_reg <= rmd;
        if (cmd.update) begin
            num_reg <= rem_reg;
            rem_reg <= nrem_reg;
            pp_reg  <= p_reg;
            p_reg   <= pacc_reg + pp_reg;
            qp_reg  <= q_reg;
            q_reg   <= qacc_reg + qp_reg;
            tqp_reg <= tq_reg;
            tq_reg  <= tacc_reg + tqp_reg;
        end
    end

    assign status.pass     = 64'(rem_reg) <= tq_reg;
    assign status.div_done = dv_done;
    assign numerator       = p_reg;
    assign denominator     = 33'(q_reg);

endmodule
`default_nettype wire

>>> hdl/continued_fraction_rationalizer_top.sv
// top level of the continued-fraction rationalizer
//
// s_axis: one item carries a signed Q31.32 value in s_tdata
// m_axis: one item carries numerator, denominator and terms used
// cfg: tolerance write, taken at cfg_valid && cfg_ready, only while idle;
// a pending config write holds off s_tready in that cycle
// each further term passes through the test state, the divider loop and
// the update state; the products come out of the divider loop by shift and add
// m_tvalid rises as the result register is loaded, after at most MAX_TERMS
// terms, 48 by default; the block works on one item at a time; the next item
// is taken back in idle once the result is registered, while the output
// register is free or being emptied and no config write is pending
// a stalled m_tready holds the result, the block waits in idle or in its
// output state and keeps s_tready low
// reset clears control, sets tolerance to 4295 and leaves no result pending
`default_nettype none
module continued_fraction_rationalizer_top
    import cfr_pkg::*;
#(
    parameter int FRAC_BITS = 32,
    parameter int MAX_TERMS = 48
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // value
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // numerator, denominator, terms_used, zero fill
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);
    cfr_cmd_t    cmd;
    cfr_status_t status;
    logic [31:0] tol_reg;
    logic [6:0]  terms;
    logic [63:0] numerator;
    logic [32:0] denominator;
    logic [102:0] res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= TOL_RESET;
        else if (cfg_valid && cfg_ready) tol_reg <= cfg_data;
        if (cmd.emit)
            res_reg <= {terms[5:0], denominator, numerator};
    end

    cfr_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd),
        .terms     (terms)
    );

    cfr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .value       (s_tdata),
        .tolerance   (tol_reg),
        .cmd         (cmd),
        .status      (status),
        .numerator   (numerator),
        .denominator (denominator)
    );

    assign m_tdata = {1'b0, res_reg};

`ifndef SYNTHESIS
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[96:64] != 33'd0)
        else $error("zero denominator");
    a_terms_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[102:97] != 6'd0)
        else $error("zero term count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed under stall");
`endif

endmodule
`default_nettype wire

>>> dv/continued_fraction_rationalizer_top_tb.sv
// self-checking testbench for the continued-fraction rationalizer top level
`timescale 1ns / 1ps
`default_nettype none

class fraction_scoreboard;
    logic [63:0]  want_num[$];
    logic [32:0]  want_den[$];
    logic [5:0]   want_terms[$];
    logic [31:0]  tolerance;
    int           errors;
    int           checked;

    function new();
        tolerance = cfr_pkg::TOL_RESET;
        errors = 0;
        checked = 0;
    endfunction

    function void note_value(logic [63:0] v);
        logic [63:0] a0;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] p_prev;
        logic [63:0] q_prev;
        logic [63:0] a;
        logic [63:0] nr;
        logic [63:0] pn;
        logic [63:0] qn;
        logic [63:0] terms;
        a0 = v[63] ? ~((~v) >> 32) : (v >> 32);
        rem = {32'd0, v[31:0]};
        num = 64'h1_0000_0000;
        p_prev = 64'd1;
        q_prev = 64'd0;
        p = a0;
        q = 64'd1;
        terms = 64'd1;
        while (rem > {32'd0, tolerance} * q && terms < 64'd48) begin
            a = num / rem;
            nr = num - a * rem;
            pn = a * p + p_prev;
            qn = a * q + q_prev;
            num = rem;
            rem = nr;
            p_prev = p;
            q_prev = q;
            p = pn;
            q = qn;
            terms = terms + 64'd1;
        end
        want_num.push_back(p);
        want_den.push_back(q[32:0]);
        want_terms.push_back(terms[5:0]);
    endfunction

    function void check_fraction(logic [103:0] d);
        logic [63:0] n;
        logic [32:0] q;
        logic [5:0]  t;
        if (want_num.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
        end
        n = want_num.pop_front();
        q = want_den.pop_front();
        t = want_terms.pop_front();
        checked++;
        if (d[63:0] !== n) begin
            $display("%0t: numerator expected %h actual %h", $time, n, d[63:0]);
            errors++;
        end
        if (d[96:64] !== q) begin
            $display("%0t: denominator expected %h actual %h", $time, q, d[96:64]);
            errors++;
        end
        if (d[102:97] !== t) begin
            $display("%0t: terms expected %0d actual %0d", $time, t, d[102:97]);
            errors++;
        end
    endfunction

    function int pending();
        return want_num.size();
    endfunction
endclass

module continued_fraction_rationalizer_top_tb;
    import cfr_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;

    fraction_scoreboard fractions = new();
    bit  tail_phase = 1'b0;
    bit  hold_off = 1'b0;
    int  cycles = 0;
    int  sent = 0;

    always #10 aclk = ~aclk;

    continued_fraction_rationalizer_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            fractions.check_fraction(m_tdata);
    end

    // receiver: random stall bursts, long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                for (n = 0; n < 6000; n++)
                    @(posedge aclk);
                hold_off = 1'b0;
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_value(logic [63:0] v);
        int gap;
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fractions.note_value(v);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (fractions.pending() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [31:0] t);
        cfg_valid <= 1'b1;
        cfg_data <= t;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        fractions.tolerance = t;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = {{32{v[63]}}, v[31:0]};
            1: v = {{48{v[63]}}, v[15:0]};
            default: ;
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [63:0] directed[$];
        logic [31:0] tols[5];
        int i;
        int k;
        directed = '{64'h0, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000,
            64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000,
            64'h0000_0003_243F_6A88, 64'hFFFF_FFFC_DBC0_9578,
            64'h0000_0000_5555_5555, 64'h0000_0000_9E37_79B9,
            64'h0000_0000_FFFF_FFFF, 64'h0000_0002_B7E1_5162,
            64'h0000_0000_0000_0002, 64'h8000_0000_0000_0001};
        tols = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd65536, 32'd4295};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[j]) send_value(directed[j]);
        drain();
        for (k = 0; k < 5; k++) begin
            write_tolerance(tols[k]);
            if (k == 0) begin
                foreach (directed[j]) send_value(directed[j]);
                hold_off = 1'b1;
            end
            for (i = 0; i < 20; i++) begin
                if (k == 4 && i >= 10)
                    tail_phase = 1'b1;
                send_value(random_value());
            end
            drain();
        end
        write_tolerance($urandom);
        for (i = 0; i < 10; i++) send_value(random_value());
        drain();
        $display("sent %0d values, checked %0d fractions over 7 tolerance settings",
            sent, fractions.checked);
        $display("covered extremes, negatives, exact values and term-limit cases");
        if (fractions.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire

>>> continued_fraction_rationalizer_top.f
hdl/cfr_pkg.sv
hdl/cfr_ctrl.sv
hdl/cfr_div.sv
hdl/cfr_dp.sv
hdl/continued_fraction_rationalizer_top.sv
dv/continued_fraction_rationalizer_top_tb.sv
